/* rtl/tvd_pkg.sv */
// Shared constants, codes and types for the tagged value deque.
package tvd_pkg;

  localparam int DEPTH     = 16;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 3;
  localparam int VTYPE_W   = 2;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef enum logic [VTYPE_W-1:0] {
    VT_NONE = 2'd0,
    VT_CHAR = 2'd1,
    VT_INT  = 2'd2,
    VT_BOOL = 2'd3
  } vtype_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_BAD_REQ = 3'd4
  } status_t;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    vtype_t             vtype;
  } entry_t;

  // Wrap a sum known to be below 2*DEPTH back into the ring.
  function automatic ptr_t wrap_add(logic [PTR_W:0] s);
    logic [PTR_W:0] lim;
    lim = (PTR_W + 1)'(DEPTH);
    if (s >= lim) begin
      return PTR_W'(s - lim);
    end
    return PTR_W'(s);
  endfunction

endpackage

/* rtl/tvd_ifs.sv */
// Valid/ready channel interfaces for deque requests and results.
interface tvd_in_if import tvd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;
  logic [VTYPE_W-1:0]        value_type;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, output op, output value, output value_type,
                  output index, input ready);
  modport sink   (input valid, input op, input value, input value_type,
                  input index, output ready);
endinterface

interface tvd_out_if import tvd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [VTYPE_W-1:0]        out_type;
  logic [STATUS_W-1:0]       status;
  logic [CNT_OUT_W-1:0]      count;

  modport source (output valid, output out_value, output out_type,
                  output status, output count, input ready);
  modport sink   (input valid, input out_value, input out_type,
                  input status, input count, output ready);
endinterface

/* rtl/tagged_value_deque_unit.sv */
// Bounded double-ended queue of tagged values on a ring buffer.
//
// in_ch carries one request per item: push front/back, pop front/back or
// read at an index counted from the front. out_ch returns exactly one
// result item per request: value, type tag, status and the entry count
// after the request.
// A request passes through the input register, then the result register,
// from which out_ch takes its result. Throughput: one item per cycle while
// out_ch takes results; the ring pointers and the register-file store
// finish each request in a single pass, and the state update lands as the
// item moves into the result register, so back-to-back requests see each
// other's effects in order.
// Reset (rst_n low, synchronous) empties the queue and drops any item held
// in either register. Store contents are not cleared; only written entries
// are ever returned.
// When out_ch stalls, the result register holds; the input register still
// takes one more item, then in_ch.ready drops until the result is taken.
module tagged_value_deque_unit import tvd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  tvd_in_if.sink    in_ch,
  tvd_out_if.source out_ch
);

  // input register
  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [VALUE_W-1:0]  s1_value_r;
  logic [VTYPE_W-1:0]  s1_type_r;
  logic [INDEX_W-1:0]  s1_index_r;

  // queue state
  entry_t store_r [DEPTH];
  ptr_t   front_r, front_nxt;
  cnt_t   cnt_r, cnt_nxt;

  // result register
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  vtype_t               out_type_r;
  status_t              out_status_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic    adv;
  logic    wr_en;
  ptr_t    wr_pos, rd_pos;
  entry_t  wr_entry, rd_entry;
  logic [VALUE_W-1:0] res_value;
  vtype_t  res_type;
  status_t res_status;

  ptr_t front_dec, front_inc, back_pos, tail_pos, idx_pos;
  logic [VALUE_W-1:0] push_value;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r    <= in_ch.op;
      s1_value_r <= in_ch.value;
      s1_type_r  <= in_ch.value_type;
      s1_index_r <= in_ch.index;
    end
  end

  // ring positions
  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = wrap_add((PTR_W + 1)'(front_r) + 1'b1);
  assign back_pos  = wrap_add((PTR_W + 1)'(front_r) + (PTR_W + 1)'(cnt_r));
  assign tail_pos  = wrap_add((PTR_W + 1)'(front_r) + (PTR_W + 1)'(cnt_r) - 1'b1);
  assign idx_pos   = wrap_add((PTR_W + 1)'(front_r) + (PTR_W + 1)'(s1_index_r[PTR_W-1:0]));

  always_comb begin
    case (vtype_t'(s1_type_r))
      VT_CHAR: push_value = {{(VALUE_W - 8){1'b0}}, s1_value_r[7:0]};
      VT_BOOL: push_value = {{(VALUE_W - 1){1'b0}}, s1_value_r[0]};
      default: push_value = s1_value_r;
    endcase
  end

  // read position depends only on the request and the pointers
  always_comb begin
    case (s1_op_r)
      OP_POP_BACK: rd_pos = tail_pos;
      OP_READ:     rd_pos = idx_pos;
      default:     rd_pos = front_r;
    endcase
  end

  assign wr_entry = '{value: push_value, vtype: vtype_t'(s1_type_r)};
  assign rd_entry = store_r[rd_pos];

  always_comb begin
    res_value  = '0;
    res_type   = VT_NONE;
    res_status = ST_BAD_REQ;
    front_nxt  = front_r;
    cnt_nxt    = cnt_r;
    wr_en      = 1'b0;
    wr_pos     = back_pos;
    case (s1_op_r)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        // type is checked before fullness
        if (vtype_t'(s1_type_r) == VT_NONE) begin
          res_status = ST_BAD_REQ;
        end else if (cnt_r == CNT_W'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          wr_en      = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          if (s1_op_r == OP_PUSH_FRONT) begin
            front_nxt = front_dec;
            wr_pos    = front_dec;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (cnt_r == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_status = ST_OK;
          cnt_nxt    = cnt_r - 1'b1;
          if (s1_op_r == OP_POP_FRONT) begin
            front_nxt = front_inc;
          end
          res_value = rd_entry.value;
          res_type  = rd_entry.vtype;
        end
      end
      OP_READ: begin
        if (cnt_r == '0) begin
          res_status = ST_EMPTY;
        end else if (CNT_OUT_W'(s1_index_r) >= CNT_OUT_W'(cnt_r)) begin
          res_status = ST_RANGE;
        end else begin
          res_status = ST_OK;
          res_value  = rd_entry.value;
          res_type   = rd_entry.vtype;
        end
      end
      default: begin
        res_status = ST_BAD_REQ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else if (adv) begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      store_r[wr_pos] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r  <= res_value;
      out_type_r   <= res_type;
      out_status_r <= res_status;
      out_count_r  <= CNT_OUT_W'(cnt_nxt);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_type  = out_type_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count     = out_count_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_typed_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_type_r != VT_NONE) |-> (out_status_r == ST_OK))
    else $error("typed result without ok status");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == CNT_OUT_W'(DEPTH)))
    else $error("full status with queue not full");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && wr_en) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("stored push did not grow count");
`endif

endmodule

/* dv/tagged_value_deque_unit_test.sv */
// Self-checking testbench for the tagged value deque: directed table, then random traffic.
module tagged_value_deque_unit_test;
  import tvd_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;
  localparam int RANDOM_PER_PHASE = 267;
  localparam int STALL_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 5;
  localparam int PRINT_CAP        = 50;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    vtype_t             vtype;
    logic [INDEX_W-1:0] index;
  } deque_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    vtype_t               vtype;
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } deque_result_t;

  typedef struct packed {
    deque_req_t    req;
    logic [4:0]    reps;
    logic          typed;
    deque_result_t want;
  } stim_row_t;

  localparam deque_result_t UNTYPED = '{32'd0, VT_NONE, ST_OK, 9'd0};
  localparam int NUM_ROWS = 25;

  // Rows with typed=1 carry a hand-written result; the rest go through the predictor.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{'{OP_POP_FRONT,  32'd0,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_EMPTY, 9'd0}},
    '{'{OP_POP_BACK,   32'd0,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_EMPTY, 9'd0}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_EMPTY, 9'd0}},
    '{'{OP_PUSH_FRONT, 32'd5,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_BAD_REQ, 9'd0}},
    '{'{OP_RSVD_FIRST, 32'hFFFF_FFFF,  VT_INT,  8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_BAD_REQ, 9'd0}},
    '{'{OP_RSVD_LAST,  32'hFFFF_FFFF,  VT_BOOL, 8'hFF},  5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_BAD_REQ, 9'd0}},
    '{'{OP_PUSH_BACK,  32'hFFFF_FF80,  VT_CHAR, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_OK, 9'd1}},
    '{'{OP_PUSH_FRONT, 32'hFFFF_FFFE,  VT_BOOL, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_OK, 9'd2}},
    '{'{OP_PUSH_BACK,  32'h8000_0000,  VT_INT,  8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_OK, 9'd3}},
    '{'{OP_PUSH_FRONT, 32'h7FFF_FFFF,  VT_INT,  8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_OK, 9'd4}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'h7FFF_FFFF, VT_INT, ST_OK, 9'd4}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'd1},   5'd1,  1'b1,
      '{32'd0, VT_BOOL, ST_OK, 9'd4}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'd2},   5'd1,  1'b1,
      '{32'h0000_0080, VT_CHAR, ST_OK, 9'd4}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'd3},   5'd1,  1'b1,
      '{32'h8000_0000, VT_INT, ST_OK, 9'd4}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'd4},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_RANGE, 9'd4}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'hFF},  5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_RANGE, 9'd4}},
    '{'{OP_PUSH_BACK,  32'hFFFF_FFFF,  VT_BOOL, 8'd0},   5'd12, 1'b0, UNTYPED},
    '{'{OP_PUSH_BACK,  32'h1234_5678,  VT_INT,  8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_FULL, 9'd16}},
    // type is checked ahead of fullness
    '{'{OP_PUSH_FRONT, 32'h1234_5678,  VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_BAD_REQ, 9'd16}},
    '{'{OP_PUSH_FRONT, 32'h0000_0041,  VT_CHAR, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_FULL, 9'd16}},
    '{'{OP_READ,       32'd0,          VT_NONE, 8'd15},  5'd1,  1'b1,
      '{32'd1, VT_BOOL, ST_OK, 9'd16}},
    '{'{OP_POP_FRONT,  32'd0,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'h7FFF_FFFF, VT_INT, ST_OK, 9'd15}},
    '{'{OP_POP_BACK,   32'd0,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'd1, VT_BOOL, ST_OK, 9'd14}},
    '{'{OP_POP_BACK,   32'd0,          VT_NONE, 8'd0},   5'd14, 1'b0, UNTYPED},
    '{'{OP_POP_FRONT,  32'd0,          VT_NONE, 8'd0},   5'd1,  1'b1,
      '{32'd0, VT_NONE, ST_EMPTY, 9'd0}}
  };

  logic clk;
  logic rst_n;

  tvd_in_if  in_ch ();
  tvd_out_if out_ch ();

  tagged_value_deque_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  logic [VALUE_W-1:0] slot_values [DEPTH];
  vtype_t             slot_tags   [DEPTH];
  int                 head_slot;
  int                 held_count;
  int                 peak_count;

  deque_result_t expected_results [$];
  logic          row_typed;
  deque_result_t row_want;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int stall_cycles;
  int requests_seen;
  int status_seen [5];
  deque_result_t predicted;
  deque_result_t oldest;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic deque_result_t predict_deque(deque_req_t r);
    deque_result_t res;
    int slot;
    logic [VALUE_W-1:0] kept;
    res  = UNTYPED;
    slot = 0;
    kept = r.value;
    case (r.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (r.vtype == VT_NONE) begin
          res.status = ST_BAD_REQ;
        end else if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (r.vtype == VT_CHAR) begin
            kept = {24'd0, r.value[7:0]};
          end else if (r.vtype == VT_BOOL) begin
            kept = {31'd0, r.value[0]};
          end
          if (r.op == OP_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot = head_slot;
          end else begin
            slot = (head_slot + held_count) % DEPTH;
          end
          slot_values[slot] = kept;
          slot_tags[slot]   = r.vtype;
          held_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (r.op == OP_POP_FRONT) begin
            slot = head_slot;
            head_slot = (head_slot + 1) % DEPTH;
          end else begin
            slot = (head_slot + held_count - 1) % DEPTH;
          end
          held_count--;
          res.value = slot_values[slot];
          res.vtype = slot_tags[slot];
        end
      end
      OP_READ: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(r.index) >= held_count) begin
          res.status = ST_RANGE;
        end else begin
          slot = (head_slot + int'(r.index)) % DEPTH;
          res.value = slot_values[slot];
          res.vtype = slot_tags[slot];
        end
      end
      default: res.status = ST_BAD_REQ;
    endcase
    res.count = CNT_OUT_W'(held_count);
    if (held_count > peak_count) begin
      peak_count = held_count;
    end
    return res;
  endfunction

  function automatic deque_req_t random_request(int mode);
    deque_req_t r;
    int pick;
    int push_w;
    int pop_w;
    case (mode)
      MODE_FILL:  begin push_w = 35; pop_w = 10; end
      MODE_DRAIN: begin push_w = 12; pop_w = 30; end
      default:    begin push_w = 20; pop_w = 18; end
    endcase
    pick = $urandom_range(99);
    if (pick < push_w) begin
      r.op = OP_PUSH_FRONT;
    end else if (pick < 2 * push_w) begin
      r.op = OP_PUSH_BACK;
    end else if (pick < 2 * push_w + pop_w) begin
      r.op = OP_POP_FRONT;
    end else if (pick < 2 * push_w + 2 * pop_w) begin
      r.op = OP_POP_BACK;
    end else if (pick < 97) begin
      r.op = OP_READ;
    end else begin
      r.op = OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
    end
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       r.value = 32'h0000_0000;
        1:       r.value = 32'h7FFF_FFFF;
        2:       r.value = 32'h8000_0000;
        default: r.value = 32'hFFFF_FFFF;
      endcase
    end else begin
      r.value = $urandom();
    end
    r.vtype = ($urandom_range(99) < 5) ? VT_NONE : vtype_t'($urandom_range(3, 1));
    pick = $urandom_range(99);
    if (held_count > 0 && pick < 70) begin
      r.index = INDEX_W'($urandom_range(held_count - 1, 0));
    end else if (pick < 85) begin
      r.index = INDEX_W'(held_count + $urandom_range(2));
    end else begin
      r.index = INDEX_W'($urandom_range(255));
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("ERROR @%0t: result %s got %0h expected %0h", $time, field, got, want);
    end
  endtask

  // Checks results first, then predicts the request accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        stall_cycles = 0;
        if (expected_results.size() == 0) begin
          report_mismatch("with nothing pending, value", out_ch.out_value, 32'd0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_ch.out_value !== oldest.value) begin
            report_mismatch("value", out_ch.out_value, oldest.value);
          end
          if (out_ch.out_type !== oldest.vtype) begin
            report_mismatch("type", 32'(out_ch.out_type), 32'(oldest.vtype));
          end
          if (out_ch.status !== oldest.status) begin
            report_mismatch("status", 32'(out_ch.status), 32'(oldest.status));
          end
          if (out_ch.count !== oldest.count) begin
            report_mismatch("count", 32'(out_ch.count), 32'(oldest.count));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        stall_cycles = 0;
        predicted = predict_deque('{in_ch.op, in_ch.value, vtype_t'(in_ch.value_type),
                                    in_ch.index});
        expected_results.push_back(row_typed ? row_want : predicted);
        status_seen[predicted.status]++;
        requests_seen++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_results.size());
        $display("tagged_value_deque_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic send_request(deque_req_t r, logic typed, deque_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= r.op;
    in_ch.value      <= r.value;
    in_ch.value_type <= r.vtype;
    in_ch.index      <= r.index;
    row_typed        <= typed;
    row_want         <= want;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    if (expected_results.size() != 0) begin
      in_ch.valid <= 1'b0;
      while (expected_results.size() != 0) begin
        @(negedge clk);
      end
    end
  endtask

  initial begin
    int mode;
    int mode_left;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = '0;
    in_ch.value      = '0;
    in_ch.value_type = '0;
    in_ch.index      = '0;
    out_ch.ready     = 1'b0;
    row_typed        = 1'b0;
    row_want         = UNTYPED;
    head_slot        = 0;
    held_count       = 0;
    peak_count       = 0;
    mismatch_count   = 0;
    stall_cycles     = 0;
    requests_seen    = 0;
    send_idle_pct    = 11;
    recv_idle_pct    = 49;
    mode             = MODE_MIXED;
    mode_left        = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (slot_values[i]) begin
      slot_values[i] = '0;
      slot_tags[i]   = VT_NONE;
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end
    end
    wait_until_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 11 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (mode_left == 0) begin
          mode      = $urandom_range(MODE_MIXED, MODE_FILL);
          mode_left = $urandom_range(40, 10);
        end
        mode_left--;
        send_request(random_request(mode), 1'b0, UNTYPED);
        // occasional full hold-off so the pipe empties mid-phase
        if ($urandom_range(99) < 2) begin
          wait_until_drained();
        end
      end
      wait_until_drained();
    end

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d requests, peak fill %0d of %0d entries.",
             requests_seen, peak_count, DEPTH);
    $display("Outcomes: %0d ok, %0d full, %0d empty, %0d out of range, %0d bad request.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], status_seen[ST_BAD_REQ]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tagged_value_deque_unit: match");
    end else begin
      $display("tagged_value_deque_unit: mismatch");
    end
    $finish;
  end

endmodule
